// ===== rtl/tccw_pkg.sv =====
// Package: text console writer geometry, command codes and queue item type.
package tccw_pkg;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELL_COUNT  = COLUMNS * ROWS;
    localparam int ADDR_W      = $clog2(CELL_COUNT);
    localparam int CNT_W       = $clog2(CELL_COUNT + 1);
    localparam int LAST_ROW    = (ROWS - 1) * COLUMNS;
    localparam int QUEUE_DEPTH = 4;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int LOC_W  = 11;
    localparam int CELL_W = 16;

    localparam logic [7:0] ATTR_RESET = 8'h0F;
    localparam logic [7:0] BLANK_CHAR = 8'h20;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_TAB     = 8'h09;

    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_SET   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    localparam logic [2:0] OP_NL    = 3'd0;
    localparam logic [2:0] OP_BS    = 3'd1;
    localparam logic [2:0] OP_TAB   = 3'd2;
    localparam logic [2:0] OP_PRINT = 3'd3;
    localparam logic [2:0] OP_NONE  = 3'd4;
    localparam logic [2:0] OP_SET   = 3'd5;
    localparam logic [2:0] OP_CLEAR = 3'd6;
    localparam logic [2:0] OP_READ  = 3'd7;

    typedef struct packed {
        logic [2:0]        op;
        logic [7:0]        char_code;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [ADDR_W-1:0] idx;
        logic              idx_ok;
    } cmd_t;

endpackage

// ===== rtl/text_console_character_writer_top.sv =====
// Top level of the text console character writer.
// Items enter through a decode register and a four-entry command queue, so the
// input side keeps accepting while the screen engine works or a result waits.
// The engine owns a cell store with one write port and one registered read port
// (one write, one registered read per cycle). Put character, set cursor and read
// cell each return one result item; a put that runs past the bottom row first
// scrolls the screen (one cell moved per cycle, then the last row blanked), and
// clear screen blanks every cell and homes the cursor. The cell
// store is not cleared by reset; its contents are undefined until written.
// text_attribute is written on cfg_data whenever cfg_valid is high.
module text_console_character_writer_top import tccw_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // char_code, target_col, target_row, cell_index
    input  logic [1:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // cursor_col, cursor_row, cursor_loc, read_cell
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // text_attribute
);

    logic [7:0] attr_reg;
    logic [7:0] attr_next;
    logic       fq_valid;
    logic       fq_ready;
    cmd_t       fq_cmd;
    logic       qb_valid;
    logic       qb_ready;
    cmd_t       qb_cmd;

    assign cfg_ready = 1'b1;

    always_comb begin
        attr_next = attr_reg;
        if (cfg_valid && cfg_ready) begin
            attr_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= ATTR_RESET;
        end else begin
            attr_reg <= attr_next;
        end
    end

    tccw_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_cmd    (fq_cmd)
    );

    tccw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    tccw_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_cmd    (qb_cmd),
        .attr     (attr_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== rtl/tccw_front.sv =====
// Front end: accepts input items, decodes them into queue commands.
module tccw_front import tccw_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // char_code, target_col, target_row, cell_index
    input  logic [1:0]  s_tuser,   // func
    output logic        q_valid,
    input  logic        q_ready,
    output cmd_t        q_cmd
);

    logic              valid_reg;
    logic              valid_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic [7:0]        char_code;
    logic [COL_W-1:0]  target_col;
    logic [ROW_W-1:0]  target_row;
    logic [10:0]       cell_index;

    assign char_code  = s_tdata[7:0];
    assign target_col = s_tdata[14:8];
    assign target_row = s_tdata[19:15];
    assign cell_index = s_tdata[30:20];

    assign s_tready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;
    assign q_cmd    = cmd_reg;

    always_comb begin
        cmd_next.char_code = char_code;
        cmd_next.col = (32'(target_col) > 32'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : target_col;
        cmd_next.row = (32'(target_row) > 32'(ROWS - 1)) ? ROW_W'(ROWS - 1) : target_row;
        cmd_next.idx    = ADDR_W'(cell_index);
        cmd_next.idx_ok = 32'(cell_index) < 32'(CELL_COUNT);
        case (s_tuser)
            FUNC_PUT: begin
                case (char_code)
                    CH_NL:   cmd_next.op = OP_NL;
                    CH_BS:   cmd_next.op = OP_BS;
                    CH_TAB:  cmd_next.op = OP_TAB;
                    default: begin
                        if (char_code inside {[8'h20:8'h7F]}) begin
                            cmd_next.op = OP_PRINT;
                        end else begin
                            cmd_next.op = OP_NONE;
                        end
                    end
                endcase
            end
            FUNC_SET:   cmd_next.op = OP_SET;
            FUNC_CLEAR: cmd_next.op = OP_CLEAR;
            default:    cmd_next.op = OP_READ;
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// ===== rtl/tccw_queue.sv =====
// Command queue between the front end and the screen engine.
module tccw_queue import tccw_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t               slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               push;
    logic               pop;

    assign in_ready  = count_reg != COUNT_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== rtl/tccw_back.sv =====
// Screen engine: cell store, cursor, scroll and clear sequencer, result register.
module tccw_back import tccw_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  cmd_t        q_cmd,
    input  logic [7:0]  attr,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // cursor_col, cursor_row, cursor_loc, read_cell
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_SCROLL = 2'd2;
    localparam logic [1:0] ST_BLANK  = 2'd3;

    logic [CELL_W-1:0] mem [CELL_COUNT];
    logic [CELL_W-1:0] rd_data_reg;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              pend_reg;
    logic              pend_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [39:0]       out_data_reg;
    logic [39:0]       out_data_next;

    logic              we;
    logic [ADDR_W-1:0] wa;
    logic [CELL_W-1:0] wd;
    logic [ADDR_W-1:0] ra;
    logic              load;
    logic [CELL_W-1:0] rd_out;
    logic              out_free;
    logic [CELL_W-1:0] blank;
    logic [ADDR_W-1:0] cur_addr;
    logic [COL_W:0]    pcol;
    logic [ROW_W:0]    prow;
    logic [LOC_W-1:0]  loc;

    assign blank    = {attr, BLANK_CHAR};
    assign cur_addr = ADDR_W'(32'(row_reg) * COLUMNS + 32'(col_reg));
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        we         = 1'b0;
        wa         = cur_addr;
        wd         = blank;
        ra         = cnt_reg[ADDR_W-1:0];
        load       = 1'b0;
        rd_out     = '0;
        q_ready    = 1'b0;
        pcol       = {1'b0, col_reg};
        prow       = {1'b0, row_reg};
        case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_ready = 1'b1;
                    case (q_cmd.op)
                        OP_READ: begin
                            if (q_cmd.idx_ok) begin
                                ra         = q_cmd.idx;
                                state_next = ST_READ;
                            end else begin
                                load = 1'b1;
                            end
                        end
                        OP_SET: begin
                            col_next = q_cmd.col;
                            row_next = q_cmd.row;
                            load     = 1'b1;
                        end
                        OP_CLEAR: begin
                            col_next   = '0;
                            row_next   = '0;
                            cnt_next   = '0;
                            state_next = ST_BLANK;
                        end
                        default: begin
                            case (q_cmd.op)
                                OP_NL: begin
                                    pcol = '0;
                                    prow = prow + 1'b1;
                                end
                                OP_BS: begin
                                    if (col_reg != '0) begin
                                        pcol = pcol - 1'b1;
                                        we   = 1'b1;
                                        wa   = cur_addr - 1'b1;
                                    end
                                end
                                OP_TAB: begin
                                    pcol = (pcol + (COL_W+1)'(4)) & ~(COL_W+1)'(3);
                                end
                                OP_PRINT: begin
                                    we   = 1'b1;
                                    wd   = {attr, q_cmd.char_code};
                                    pcol = pcol + 1'b1;
                                end
                                default: begin
                                end
                            endcase
                            if (32'(pcol) >= 32'(COLUMNS)) begin
                                pcol = '0;
                                prow = prow + 1'b1;
                            end
                            col_next = pcol[COL_W-1:0];
                            if (32'(prow) >= 32'(ROWS)) begin
                                row_next   = ROW_W'(ROWS - 1);
                                cnt_next   = CNT_W'(COLUMNS);
                                pend_next  = 1'b0;
                                state_next = ST_SCROLL;
                            end else begin
                                row_next = prow[ROW_W-1:0];
                                load     = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_READ: begin
                rd_out     = rd_data_reg;
                load       = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCROLL: begin
                // read one row down, write the cell read on the previous cycle
                we = pend_reg;
                wa = ADDR_W'(cnt_reg - CNT_W'(COLUMNS + 1));
                wd = rd_data_reg;
                if (cnt_reg == CNT_W'(CELL_COUNT)) begin
                    cnt_next   = CNT_W'(LAST_ROW);
                    state_next = ST_BLANK;
                end else begin
                    cnt_next  = cnt_reg + 1'b1;
                    pend_next = 1'b1;
                end
            end
            default: begin
                we = 1'b1;
                wa = cnt_reg[ADDR_W-1:0];
                if (cnt_reg == CNT_W'(CELL_COUNT - 1)) begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
        endcase
    end

    assign loc = LOC_W'(32'(row_next) * COLUMNS + 32'(col_next));

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load) begin
            out_valid_next = 1'b1;
            out_data_next  = {1'b0, rd_out, loc, row_next, col_next};
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[ra];
    end

endmodule

// ===== rtl/tccw_checker.sv =====
// Port-level checks for the text console writer, bound to the top level.
module tccw_checker import tccw_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(m_tdata[6:0]) < COLUMNS) && (32'(m_tdata[11:7]) < ROWS))
        else $error("cursor outside the screen");

    a_location: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[22:12] ==
            LOC_W'(32'(m_tdata[11:7]) * COLUMNS + 32'(m_tdata[6:0])))
        else $error("cursor location does not match row and column");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result item right after reset");

endmodule

bind text_console_character_writer_top tccw_checker u_tccw_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
